### rtl/core/dhs_pkg.sv
// ----------------------------------------------------------------------------
// dhs_pkg
// types, codes and helpers shared by the domain health supervisor
// ----------------------------------------------------------------------------
package dhs_pkg;

	localparam int NUM_SLOTS_DEF = 8;
	localparam logic [15:0] CHECK_INTERVAL_RST = 16'd10;
	localparam logic [31:0] GEN_CTR_RST = 32'd1;

	typedef enum logic [3:0] {
		REQ_REGISTER    = 4'd0,
		REQ_PROGRESS    = 4'd1,
		REQ_IDLE        = 4'd2,
		REQ_SELF_TEST   = 4'd3,
		REQ_ISOLATE     = 4'd4,
		REQ_TICK        = 4'd5,
		REQ_POLL        = 4'd6,
		REQ_FENCE_START = 4'd7,
		REQ_FENCE_DONE  = 4'd8
	} req_kind_t;

	typedef enum logic [2:0] {
		HS_STARTING   = 3'd0,
		HS_HEALTHY    = 3'd1,
		HS_DEGRADED   = 3'd2,
		HS_RECOVERING = 3'd3,
		HS_ISOLATED   = 3'd4,
		HS_FENCING    = 3'd5,
		HS_SAFE       = 3'd6,
		HS_IDLE       = 3'd7
	} health_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_FENCE   = 2'd1,
		EV_RESTART = 2'd2,
		EV_SAFE    = 2'd3
	} ev_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OP,
		ST_SCAN_RD,
		ST_SCAN_OP,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic [3:0]  req_type;
		logic [63:0] now_ms;
		logic [2:0]  slot_index;
		logic [31:0] handle_generation;
		logic [31:0] handle_epoch;
		logic [63:0] marker_value;
		logic [31:0] heartbeat_ms;
		logic [31:0] recovery_ms;
		logic [7:0]  budget;
		logic        pass_flag;
		logic        query_mode;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [1:0]  event_kind;
		logic [2:0]  event_slot;
		logic [31:0] event_generation;
		logic [31:0] event_epoch;
		logic        output_permitted;
	} res_t;

	typedef struct packed {
		logic [31:0] generation;
		health_t     health;
		logic [31:0] epoch;
		logic [63:0] marker;
		logic [7:0]  restarts_used;
		logic [31:0] heartbeat_limit;
		logic [31:0] recovery_limit;
		logic [7:0]  restart_limit;
		logic [63:0] deadline;
	} slot_entry_t;

	// now plus span, saturating at all ones
	function automatic logic [63:0] deadline_from(input logic [63:0] now,
		input logic [31:0] span);
		logic [64:0] sum;
		sum = {1'b0, now} + {33'd0, span};
		return sum[64] ? {64{1'b1}} : sum[63:0];
	endfunction

endpackage

### rtl/core/dhs_ifs.sv
// ----------------------------------------------------------------------------
// dhs_ifs
// request, result and configuration channels
// ----------------------------------------------------------------------------
interface dhs_req_if import dhs_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dhs_res_if import dhs_pkg::*; ();
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dhs_cfg_if ();
	logic        valid;
	logic        ready;
	logic [15:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/dhs_slot_mem.sv
// ----------------------------------------------------------------------------
// dhs_slot_mem
// per-slot record store, one write and one registered read port
// ----------------------------------------------------------------------------
module dhs_slot_mem import dhs_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	parameter int IDX_W = 3
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  slot_entry_t      wdata,
	input  logic [IDX_W-1:0] raddr,
	output slot_entry_t      rdata
);

	slot_entry_t mem [NUM_SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/dhs_ctrl.sv
// ----------------------------------------------------------------------------
// dhs_ctrl
// request sequencer: read-modify-write of slot records, scans, result buffer
// ----------------------------------------------------------------------------
module dhs_ctrl import dhs_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	parameter int IDX_W = 3,
	parameter int CNT_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [15:0]      check_interval,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req_data,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res_data,
	output logic             mem_we,
	output logic [IDX_W-1:0] mem_waddr,
	output slot_entry_t      mem_wdata,
	output logic [IDX_W-1:0] mem_raddr,
	input  slot_entry_t      mem_rdata
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_SLOTS - 1);

	ctrl_state_t state_q, state_nxt;
	req_t req_q;
	logic [IDX_W-1:0] idx_q, t_q, t_nxt, cursor_q, free_idx;
	logic [CNT_W-1:0] cnt_q;
	logic in_range_q, free_found, reg_take, sweep_go, scan_last;
	logic [NUM_SLOTS-1:0] active_q;
	logic [31:0] gen_ctr_q, gen_use;
	logic [63:0] last_sweep_q;
	logic hit_q, cap, fin_hit;
	ev_t hit_kind_q, kind_now, fin_kind;
	logic [IDX_W-1:0] hit_slot_q, fin_slot;
	logic [31:0] hit_gen_q, hit_ep_q, fin_gen, fin_ep;
	res_t pend_q, op_res, scan_res, out_q;
	logic out_valid_q, load_out, ok, expire;
	logic [6:0] s_wide_in, s_wide_t, s_wide_f;
	logic [63:0] since;
	health_t new_h;
	slot_entry_t d;
	logic [31:0] ep_inc;

	assign d = mem_rdata;
	assign s_wide_in = {4'd0, req_data.slot_index};
	assign req_ready = (state_q == ST_IDLE);
	assign load_out = (state_q == ST_EMIT) && (!out_valid_q || res_ready);
	assign res_valid = out_valid_q;
	assign res_data = out_q;
	assign t_nxt = (t_q == LAST_IDX) ? '0 : t_q + 1'b1;
	assign scan_last = (cnt_q == LAST_CNT);
	assign since = req_q.now_ms - last_sweep_q;
	assign sweep_go = since >= {48'd0, check_interval};

	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	assign gen_use = (gen_ctr_q == 32'd0) ? 32'd1 : gen_ctr_q;
	assign ok = in_range_q && active_q[idx_q] &&
		d.generation == req_q.handle_generation && d.epoch == req_q.handle_epoch;
	assign ep_inc = (d.epoch + 32'd1 == 32'd0) ? 32'd1 : d.epoch + 32'd1;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_nxt = ST_OP;
			end
			ST_OP: begin
				if (req_q.req_type == REQ_POLL ||
					(req_q.req_type == REQ_TICK && sweep_go)) state_nxt = ST_SCAN_RD;
				else state_nxt = ST_EMIT;
			end
			ST_SCAN_RD: state_nxt = ST_SCAN_OP;
			ST_SCAN_OP: state_nxt = scan_last ? ST_EMIT : ST_SCAN_RD;
			ST_EMIT: begin
				if (load_out) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// single-slot operations and scan expiry writes
	always_comb begin
		op_res = '0;
		op_res.status = 1'b1;
		reg_take = 1'b0;
		mem_we = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = d;
		expire = 1'b0;
		s_wide_t = {{(7-IDX_W){1'b0}}, free_idx};
		if (state_q == ST_OP) begin
			case (req_q.req_type)
				REQ_REGISTER: begin
					if (req_q.heartbeat_ms != 32'd0 && req_q.recovery_ms != 32'd0 &&
						free_found) begin
						reg_take = 1'b1;
						mem_we = 1'b1;
						mem_waddr = free_idx;
						mem_wdata.generation = gen_use;
						mem_wdata.health = HS_STARTING;
						mem_wdata.epoch = 32'd1;
						mem_wdata.marker = '0;
						mem_wdata.restarts_used = '0;
						mem_wdata.heartbeat_limit = req_q.heartbeat_ms;
						mem_wdata.recovery_limit = req_q.recovery_ms;
						mem_wdata.restart_limit = req_q.budget;
						mem_wdata.deadline = deadline_from(req_q.now_ms, req_q.recovery_ms);
						op_res.status = 1'b0;
						op_res.event_slot = s_wide_t[2:0];
						op_res.event_generation = gen_use;
						op_res.event_epoch = 32'd1;
					end
				end
				REQ_PROGRESS: begin
					if (ok && d.health inside {HS_STARTING, HS_HEALTHY, HS_DEGRADED, HS_IDLE}
						&& req_q.marker_value > d.marker) begin
						mem_we = 1'b1;
						mem_wdata.marker = req_q.marker_value;
						mem_wdata.health = HS_HEALTHY;
						mem_wdata.deadline = deadline_from(req_q.now_ms, d.heartbeat_limit);
						op_res.status = 1'b0;
					end
				end
				REQ_IDLE: begin
					if (ok && d.health == HS_HEALTHY) begin
						mem_we = 1'b1;
						mem_wdata.health = HS_IDLE;
						mem_wdata.deadline = {64{1'b1}};
						op_res.status = 1'b0;
					end
				end
				REQ_SELF_TEST: begin
					if (ok && d.health inside {HS_RECOVERING, HS_STARTING}) begin
						mem_we = 1'b1;
						mem_wdata.health = req_q.pass_flag ? HS_STARTING : HS_ISOLATED;
						mem_wdata.marker = '0;
						mem_wdata.deadline = deadline_from(req_q.now_ms, d.recovery_limit);
						op_res.status = 1'b0;
					end
				end
				REQ_ISOLATE: begin
					if (ok && d.health != HS_SAFE) begin
						mem_we = 1'b1;
						mem_wdata.health = HS_ISOLATED;
						op_res.status = 1'b0;
					end
				end
				REQ_TICK: op_res.status = 1'b0;
				REQ_POLL: op_res.status = 1'b0;
				REQ_FENCE_START: begin
					if (ok && d.health == HS_ISOLATED) begin
						mem_we = 1'b1;
						mem_wdata.health = HS_FENCING;
						op_res.status = 1'b0;
					end
				end
				REQ_FENCE_DONE: begin
					if (req_q.query_mode) begin
						op_res.status = 1'b0;
						op_res.output_permitted = ok && d.health inside {HS_HEALTHY, HS_IDLE};
					end else if (ok && d.health == HS_FENCING) begin
						mem_we = 1'b1;
						op_res.status = 1'b0;
						op_res.event_slot = req_q.slot_index;
						op_res.event_generation = d.generation;
						if (!req_q.pass_flag || d.restarts_used >= d.restart_limit) begin
							mem_wdata.health = HS_SAFE;
							op_res.event_kind = EV_SAFE;
							op_res.event_epoch = d.epoch;
						end else begin
							mem_wdata.restarts_used = d.restarts_used + 8'd1;
							mem_wdata.epoch = ep_inc;
							mem_wdata.health = HS_RECOVERING;
							mem_wdata.deadline = deadline_from(req_q.now_ms, d.recovery_limit);
							op_res.event_kind = EV_RESTART;
							op_res.event_epoch = ep_inc;
						end
					end
				end
				default: op_res.status = 1'b1;
			endcase
		end else if (state_q == ST_SCAN_OP) begin
			expire = active_q[t_q] &&
				d.health inside {HS_STARTING, HS_HEALTHY, HS_DEGRADED, HS_RECOVERING} &&
				req_q.now_ms >= d.deadline;
			mem_we = expire;
			mem_waddr = t_q;
			mem_wdata.health = HS_ISOLATED;
		end
	end

	// scan hit tracking
	always_comb begin
		new_h = expire ? HS_ISOLATED : d.health;
		case (new_h)
			HS_ISOLATED:   kind_now = EV_FENCE;
			HS_RECOVERING: kind_now = EV_RESTART;
			HS_SAFE:       kind_now = EV_SAFE;
			default:       kind_now = EV_NONE;
		endcase
		cap = (state_q == ST_SCAN_OP) && (req_q.req_type == REQ_POLL) && !hit_q &&
			active_q[t_q] && kind_now != EV_NONE;
		fin_hit = hit_q || cap;
		fin_kind = hit_q ? hit_kind_q : kind_now;
		fin_slot = hit_q ? hit_slot_q : t_q;
		fin_gen = hit_q ? hit_gen_q : d.generation;
		fin_ep = hit_q ? hit_ep_q : d.epoch;
		s_wide_f = {{(7-IDX_W){1'b0}}, fin_slot};
		scan_res = '0;
		if (fin_hit && req_q.req_type == REQ_POLL) begin
			scan_res.event_kind = fin_kind;
			scan_res.event_slot = s_wide_f[2:0];
			scan_res.event_generation = fin_gen;
			scan_res.event_epoch = fin_ep;
		end
	end

	// read address
	always_comb begin
		case (state_q)
			ST_IDLE:    mem_raddr = s_wide_in[IDX_W-1:0];
			ST_SCAN_RD: mem_raddr = t_q;
			default:    mem_raddr = idx_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			active_q <= '0;
			gen_ctr_q <= GEN_CTR_RST;
			last_sweep_q <= '0;
			cursor_q <= '0;
			out_valid_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (reg_take) begin
				active_q[free_idx] <= 1'b1;
				gen_ctr_q <= gen_use + 32'd1;
			end
			if (state_q == ST_OP) begin
				hit_q <= 1'b0;
				if (req_q.req_type == REQ_TICK && sweep_go) last_sweep_q <= req_q.now_ms;
			end
			if (cap) hit_q <= 1'b1;
			if (state_q == ST_SCAN_OP && scan_last && req_q.req_type == REQ_POLL &&
				fin_hit) begin
				cursor_q <= (fin_slot == LAST_IDX) ? '0 : fin_slot + 1'b1;
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (res_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			req_q <= req_data;
			idx_q <= s_wide_in[IDX_W-1:0];
			in_range_q <= s_wide_in < 7'(NUM_SLOTS);
		end
		if (state_q == ST_OP) begin
			pend_q <= op_res;
			t_q <= cursor_q;
			cnt_q <= '0;
		end
		if (state_q == ST_SCAN_OP) begin
			t_q <= t_nxt;
			cnt_q <= cnt_q + 1'b1;
			if (scan_last) pend_q <= scan_res;
		end
		if (cap) begin
			hit_kind_q <= kind_now;
			hit_slot_q <= t_q;
			hit_gen_q <= d.generation;
			hit_ep_q <= d.epoch;
		end
		if (load_out) out_q <= pend_q;
	end

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("second beat taken while an item is in flight");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || res_ready))
		else $error("result buffer overwritten");
	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_OP || state_q == ST_SCAN_OP))
		else $error("slot write outside an execute step");
	a_hit_kind: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> (hit_kind_q != EV_NONE))
		else $error("recorded poll hit without an event");

endmodule

### rtl/core/domain_health_supervisor.sv
// ----------------------------------------------------------------------------
// domain_health_supervisor
// watchdog table of supervised domains with fencing and restart budget
// ----------------------------------------------------------------------------
// One request is in work at a time. A slot request (register, progress,
// idle, self test, isolate, fence start, fence done, output query) and an
// ungated tick go from accept to result through memory read, execute and
// write back, and result load. A sweeping tick and every poll walk all
// NUM_SLOTS slot records through the single-read-port record memory, with
// a read step and an execute step per slot. The next request is taken while
// the previous result still waits at the output.
module domain_health_supervisor import dhs_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	dhs_req_if.sink    req,
	dhs_res_if.source  res,
	dhs_cfg_if.sink    cfg
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);

	logic [15:0] interval_q;
	logic mem_we;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;
	slot_entry_t mem_wdata, mem_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= CHECK_INTERVAL_RST;
		end else if (cfg.valid) begin
			interval_q <= cfg.data;
		end
	end

	dhs_slot_mem #(.NUM_SLOTS(NUM_SLOTS), .IDX_W(IDX_W)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	dhs_ctrl #(.NUM_SLOTS(NUM_SLOTS), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.check_interval (interval_q),
		.req_valid      (req.valid),
		.req_ready      (req.ready),
		.req_data       (req.data),
		.res_valid      (res.valid),
		.res_ready      (res.ready),
		.res_data       (res.data),
		.mem_we         (mem_we),
		.mem_waddr      (mem_waddr),
		.mem_wdata      (mem_wdata),
		.mem_raddr      (mem_raddr),
		.mem_rdata      (mem_rdata)
	);

endmodule

### test/tb_domain_health_supervisor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_domain_health_supervisor
// checks the domain health supervisor against a behavioural slot table
// ----------------------------------------------------------------------------
// Requests go in through the request channel. A local copy of the slot table
// works out the expected result of each accepted beat, and a checker compares
// every result beat with the oldest expectation. Directed tests go first, then
// random lifecycle traffic under varying back-pressure and check intervals.
// ----------------------------------------------------------------------------
module tb_domain_health_supervisor;
	import dhs_pkg::*;

	localparam int NSLOT = 8;

	logic clk;
	logic arst_n;

	dhs_req_if req_ch ();
	dhs_res_if res_ch ();
	dhs_cfg_if cfg_ch ();

	domain_health_supervisor dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.res    (res_ch.source),
		.cfg    (cfg_ch.sink)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// model of the slot table
	logic [15:0]  mdl_interval;
	logic         mdl_active [NSLOT];
	logic [31:0]  mdl_gen [NSLOT];
	health_t      mdl_health [NSLOT];
	logic [31:0]  mdl_epoch [NSLOT];
	logic [63:0]  mdl_marker [NSLOT];
	logic [7:0]   mdl_used [NSLOT];
	logic [31:0]  mdl_hb [NSLOT];
	logic [31:0]  mdl_rc [NSLOT];
	logic [7:0]   mdl_budget [NSLOT];
	logic [63:0]  mdl_deadline [NSLOT];
	logic [31:0]  mdl_gen_ctr;
	logic [63:0]  mdl_last_sweep;
	logic [2:0]   mdl_cursor;

	res_t   pending_results [$];
	int     mismatch_count;
	bit     timed_out;
	int     src_idle_pct;
	int     snk_idle_pct;
	int     hold_cycles;
	logic [63:0] clock_ms;

	function automatic logic [63:0] sat_add(logic [63:0] a, logic [31:0] b);
		logic [64:0] t;
		t = {1'b0, a} + {33'd0, b};
		return t[64] ? '1 : t[63:0];
	endfunction

	function automatic bit handle_valid(logic [2:0] s, logic [31:0] g, logic [31:0] e);
		return mdl_active[s] && mdl_gen[s] == g && mdl_epoch[s] == e;
	endfunction

	function automatic void sweep_deadlines(logic [63:0] now);
		for (int s = 0; s < NSLOT; s++)
			if (mdl_active[s] && (mdl_health[s] == HS_STARTING ||
					mdl_health[s] == HS_HEALTHY || mdl_health[s] == HS_DEGRADED ||
					mdl_health[s] == HS_RECOVERING) && now >= mdl_deadline[s])
				mdl_health[s] = HS_ISOLATED;
	endfunction

	function automatic void model_reset();
		mdl_interval = CHECK_INTERVAL_RST;
		for (int s = 0; s < NSLOT; s++) begin
			mdl_active[s] = 1'b0;
			mdl_gen[s] = '0;
			mdl_health[s] = HS_STARTING;
			mdl_epoch[s] = '0;
			mdl_marker[s] = '0;
			mdl_used[s] = '0;
			mdl_hb[s] = '0;
			mdl_rc[s] = '0;
			mdl_budget[s] = '0;
			mdl_deadline[s] = '0;
		end
		mdl_gen_ctr = GEN_CTR_RST;
		mdl_last_sweep = '0;
		mdl_cursor = '0;
	endfunction

	function automatic res_t supervise(req_t r);
		res_t o;
		logic [2:0] s;
		logic [31:0] g;
		int f;
		bit ok;
		ev_t k;
		logic [2:0] t;
		s = r.slot_index;
		ok = handle_valid(s, r.handle_generation, r.handle_epoch);
		o = '0;
		o.status = 1'b1;
		case (r.req_type)
			REQ_REGISTER: begin
				f = -1;
				for (int i = NSLOT - 1; i >= 0; i--)
					if (!mdl_active[i])
						f = i;
				if (r.heartbeat_ms != 0 && r.recovery_ms != 0 && f >= 0) begin
					g = mdl_gen_ctr;
					mdl_gen_ctr++;
					if (g == 0) begin
						g = mdl_gen_ctr;
						mdl_gen_ctr++;
					end
					mdl_active[f] = 1'b1;
					mdl_gen[f] = g;
					mdl_health[f] = HS_STARTING;
					mdl_epoch[f] = 32'd1;
					mdl_marker[f] = '0;
					mdl_used[f] = '0;
					mdl_hb[f] = r.heartbeat_ms;
					mdl_rc[f] = r.recovery_ms;
					mdl_budget[f] = r.budget;
					mdl_deadline[f] = sat_add(r.now_ms, r.recovery_ms);
					o.status = 1'b0;
					o.event_slot = f[2:0];
					o.event_generation = g;
					o.event_epoch = 32'd1;
				end
			end
			REQ_PROGRESS: begin
				if (ok && (mdl_health[s] == HS_STARTING || mdl_health[s] == HS_HEALTHY ||
						mdl_health[s] == HS_DEGRADED || mdl_health[s] == HS_IDLE) &&
						r.marker_value > mdl_marker[s]) begin
					mdl_marker[s] = r.marker_value;
					mdl_health[s] = HS_HEALTHY;
					mdl_deadline[s] = sat_add(r.now_ms, mdl_hb[s]);
					o.status = 1'b0;
				end
			end
			REQ_IDLE: begin
				if (ok && mdl_health[s] == HS_HEALTHY) begin
					mdl_health[s] = HS_IDLE;
					mdl_deadline[s] = '1;
					o.status = 1'b0;
				end
			end
			REQ_SELF_TEST: begin
				if (ok && (mdl_health[s] == HS_RECOVERING || mdl_health[s] == HS_STARTING)) begin
					mdl_health[s] = r.pass_flag ? HS_STARTING : HS_ISOLATED;
					mdl_marker[s] = '0;
					mdl_deadline[s] = sat_add(r.now_ms, mdl_rc[s]);
					o.status = 1'b0;
				end
			end
			REQ_ISOLATE: begin
				if (ok && mdl_health[s] != HS_SAFE) begin
					mdl_health[s] = HS_ISOLATED;
					o.status = 1'b0;
				end
			end
			REQ_TICK: begin
				o.status = 1'b0;
				if (r.now_ms - mdl_last_sweep >= {48'd0, mdl_interval}) begin
					mdl_last_sweep = r.now_ms;
					sweep_deadlines(r.now_ms);
				end
			end
			REQ_POLL: begin
				o.status = 1'b0;
				sweep_deadlines(r.now_ms);
				for (int i = 0; i < NSLOT; i++) begin
					t = mdl_cursor + i[2:0];
					k = EV_NONE;
					if (mdl_active[t]) begin
						if (mdl_health[t] == HS_ISOLATED)
							k = EV_FENCE;
						else if (mdl_health[t] == HS_RECOVERING)
							k = EV_RESTART;
						else if (mdl_health[t] == HS_SAFE)
							k = EV_SAFE;
					end
					if (k != EV_NONE) begin
						o.event_kind = k;
						o.event_slot = t;
						o.event_generation = mdl_gen[t];
						o.event_epoch = mdl_epoch[t];
						mdl_cursor = t + 3'd1;
						break;
					end
				end
			end
			REQ_FENCE_START: begin
				if (ok && mdl_health[s] == HS_ISOLATED) begin
					mdl_health[s] = HS_FENCING;
					o.status = 1'b0;
				end
			end
			REQ_FENCE_DONE: begin
				if (r.query_mode) begin
					o.status = 1'b0;
					o.output_permitted = ok && (mdl_health[s] == HS_HEALTHY ||
						mdl_health[s] == HS_IDLE);
				end else if (ok && mdl_health[s] == HS_FENCING) begin
					o.status = 1'b0;
					if (!r.pass_flag || mdl_used[s] >= mdl_budget[s]) begin
						mdl_health[s] = HS_SAFE;
						o.event_kind = EV_SAFE;
					end else begin
						mdl_used[s]++;
						mdl_epoch[s]++;
						if (mdl_epoch[s] == 0)
							mdl_epoch[s] = 32'd1;
						mdl_health[s] = HS_RECOVERING;
						mdl_deadline[s] = sat_add(r.now_ms, mdl_rc[s]);
						o.event_kind = EV_RESTART;
					end
					o.event_slot = s;
					o.event_generation = mdl_gen[s];
					o.event_epoch = mdl_epoch[s];
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic send_request(req_t r);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_results.push_back(supervise(r));
	endtask

	task automatic write_interval(logic [15:0] v);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		mdl_interval = v;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result beat %p", res_ch.data);
				end else begin
					res_t e;
					e = pending_results.pop_front();
					if (res_ch.data.status !== e.status ||
							res_ch.data.event_kind !== e.event_kind ||
							res_ch.data.event_slot !== e.event_slot ||
							res_ch.data.event_generation !== e.event_generation ||
							res_ch.data.event_epoch !== e.event_epoch ||
							res_ch.data.output_permitted !== e.output_permitted) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("result mismatch: expected %p actual %p", e, res_ch.data);
					end
				end
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	function automatic req_t blank_req();
		req_t r;
		r = '0;
		r.now_ms = clock_ms;
		return r;
	endfunction

	function automatic req_t pick_request();
		req_t r;
		int s;
		int m;
		r = blank_req();
		clock_ms = clock_ms + $urandom_range(6);
		r.now_ms = clock_ms;
		s = $urandom_range(NSLOT - 1);
		r.slot_index = s[2:0];
		r.handle_generation = mdl_gen[s];
		r.handle_epoch = mdl_epoch[s];
		m = $urandom_range(99);
		if (m < 6) begin
			r.handle_generation = $urandom;
			r.handle_epoch = ($urandom_range(1)) ? $urandom : mdl_epoch[s] - 1;
		end
		r.req_type = req_kind_t'($urandom_range(8));
		if ($urandom_range(99) < 3)
			r.req_type = 4'($urandom_range(15));
		case (mdl_health[s])
			HS_ISOLATED: if ($urandom_range(1)) r.req_type = REQ_FENCE_START;
			HS_FENCING: if ($urandom_range(2) != 0) r.req_type = REQ_FENCE_DONE;
			HS_SAFE: if ($urandom_range(3) == 0) r.req_type = REQ_REGISTER;
			default: ;
		endcase
		r.marker_value = ($urandom_range(9) == 0) ? {$urandom, $urandom} :
			mdl_marker[s] + $urandom_range(3);
		r.heartbeat_ms = ($urandom_range(15) == 0) ? $urandom_range(1) : $urandom_range(1, 60);
		r.recovery_ms = ($urandom_range(15) == 0) ? $urandom_range(1) : $urandom_range(1, 80);
		if ($urandom_range(31) == 0) begin
			r.heartbeat_ms = $urandom;
			r.recovery_ms = $urandom;
		end
		r.budget = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(3));
		r.pass_flag = ($urandom_range(3) != 0);
		r.query_mode = 1'($urandom_range(1));
		if (r.req_type == REQ_FENCE_DONE && mdl_health[s] == HS_FENCING)
			r.query_mode = ($urandom_range(4) == 0);
		return r;
	endfunction

	task automatic run_random(int n);
		for (int i = 0; i < n; i++)
			send_request(pick_request());
	endtask

	task automatic test_directed();
		req_t r;
		r = blank_req();
		r.req_type = REQ_REGISTER;
		r.heartbeat_ms = 0;
		r.recovery_ms = 5;
		send_request(r);
		r.heartbeat_ms = 5;
		r.recovery_ms = 0;
		send_request(r);
		for (int i = 0; i < NSLOT + 1; i++) begin
			r = blank_req();
			r.req_type = REQ_REGISTER;
			r.heartbeat_ms = (i == 0) ? '1 : 32'd20;
			r.recovery_ms = (i == 0) ? '1 : 32'd30;
			r.budget = (i == 1) ? 8'hff : 8'd1;
			r.now_ms = (i == 0) ? 64'hffff_ffff_ffff_fff0 : clock_ms;
			send_request(r);
		end
		r = blank_req();
		r.req_type = REQ_PROGRESS;
		r.slot_index = 3'd7;
		r.handle_generation = mdl_gen[7];
		r.handle_epoch = mdl_epoch[7];
		r.marker_value = '1;
		send_request(r);
		send_request(r);
		r.req_type = REQ_IDLE;
		send_request(r);
		r.req_type = REQ_FENCE_DONE;
		r.query_mode = 1'b1;
		send_request(r);
		r = blank_req();
		r.req_type = REQ_ISOLATE;
		r.slot_index = 3'd2;
		r.handle_generation = mdl_gen[2];
		r.handle_epoch = mdl_epoch[2];
		send_request(r);
		r.req_type = REQ_POLL;
		send_request(r);
		r.req_type = REQ_FENCE_START;
		send_request(r);
		r.req_type = REQ_FENCE_DONE;
		r.pass_flag = 1'b1;
		send_request(r);
		r.handle_epoch = mdl_epoch[2];
		r.req_type = REQ_SELF_TEST;
		r.pass_flag = 1'b0;
		send_request(r);
		r.req_type = REQ_FENCE_START;
		send_request(r);
		r.req_type = REQ_FENCE_DONE;
		r.pass_flag = 1'b1;
		send_request(r);
		r.req_type = REQ_ISOLATE;
		send_request(r);
		r.req_type = 4'd15;
		send_request(r);
		r = blank_req();
		r.req_type = REQ_TICK;
		r.now_ms = 64'd1000;
		send_request(r);
		r.req_type = REQ_POLL;
		send_request(r);
		clock_ms = 64'd1000;
	endtask

	task automatic test_intervals();
		logic [15:0] settings [4];
		settings = '{16'd0, 16'hffff, 16'd1, 16'd17};
		foreach (settings[i]) begin
			write_interval(settings[i]);
			for (int k = 0; k < 40; k++) begin
				req_t r;
				r = pick_request();
				if (k % 3 == 0)
					r.req_type = REQ_TICK;
				send_request(r);
			end
		end
	endtask

	task automatic test_backpressure();
		hold_cycles = 300;
		run_random(60);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		run_random(20);
	endtask

	task automatic test_random_traffic();
		src_idle_pct = 6;
		snk_idle_pct = 77;
		run_random(450);
		src_idle_pct = 77;
		snk_idle_pct = 6;
		run_random(450);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		run_random(450);
	endtask

	initial begin
		timed_out = 1'b0;
		#60_000_000;
		timed_out = 1'b1;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		mismatch_count = 0;
		hold_cycles = 0;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		clock_ms = '0;
		model_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_intervals();
		test_backpressure();
		test_random_traffic();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
